/* src/psa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_pkg
// shared sizes and state codes for producer session admission
// ----------------------------------------------------------------------------
package psa_pkg;

   localparam int ID_W          = 64;
   localparam int STAMP_W       = 64;
   localparam int RETIRED_SLOTS = 16;
   localparam int CNT_W         = $clog2(RETIRED_SLOTS + 1);
   localparam int IDX_W         = (RETIRED_SLOTS > 1) ? $clog2(RETIRED_SLOTS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_DECIDE = 3'b100
   } state_type;

endpackage

/* src/psa_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa request and response channels
// valid/ready channels carrying admission requests and their verdicts
// ----------------------------------------------------------------------------
interface psa_req_if;
   logic                               valid;
   logic                               ready;
   logic        [psa_pkg::ID_W-1:0]    producer_id;
   logic signed [psa_pkg::STAMP_W-1:0] source_stamp;

   modport source (output valid, output producer_id, output source_stamp, input ready);
   modport sink   (input valid, input producer_id, input source_stamp, output ready);
endinterface

interface psa_rsp_if;
   logic valid;
   logic ready;
   logic accept;
   logic transitioned;
   logic replay;
   logic stale;
   logic invalid;

   modport source (output valid, output accept, output transitioned, output replay,
                   output stale, output invalid, input ready);
   modport sink   (input valid, input accept, input transitioned, input replay,
                   input stale, input invalid, output ready);
endinterface

/* src/producer_session_admission.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// producer_session_admission
// admits requests by producer id and source stamp, tracking retired producers
// ----------------------------------------------------------------------------
// req_bus carries one request (producer id, signed source stamp); rsp_bus
// returns one verdict per request: accept, transitioned, replay, stale and
// invalid. A request is taken when valid and ready are both high.
// The block handles one request at a time. After a request is taken it scans
// the retired-id memory, one entry per cycle through its single read port,
// waits for the last compare, then decides and updates state. With no
// producer retired no entry is read; otherwise every entry below the
// retired count is read, so the scan length is set by that count and the
// memory's one read per cycle.
// Ready rises in the cycle the verdict appears, so a new request is taken
// only once the previous one is decided.
// The verdict sits in an output register, so the next request is taken while
// it waits; if the receiver still stalls when that next request is decided,
// the block holds in its decide step until the register frees up.
// Synchronous reset clears the current producer, the latest stamp and the
// retired count; the retired-id memory is not cleared since only entries
// below the count are ever read.
// ----------------------------------------------------------------------------
module producer_session_admission (
   input  logic                clock,
   input  logic                reset,
   psa_req_if.sink             req_bus,
   psa_rsp_if.source           rsp_bus
);
   import psa_pkg::*;

   state_type                 state_ff, state_in;

   logic        [ID_W-1:0]    cur_id_ff, cur_id_in;
   logic signed [STAMP_W-1:0] latest_ff, latest_in;
   logic        [CNT_W-1:0]   count_ff, count_in;

   logic        [ID_W-1:0]    id_ff, id_in;
   logic signed [STAMP_W-1:0] stamp_ff, stamp_in;
   logic        [CNT_W-1:0]   idx_ff, idx_in;
   logic                      pend_ff, pend_in;
   logic                      hit_ff, hit_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      acc_ff, acc_in;
   logic                      trans_ff, trans_in;
   logic                      replay_ff, replay_in;
   logic                      stale_ff, stale_in;
   logic                      inv_ff, inv_in;

   // retired-id memory
   logic        [ID_W-1:0]    retired_mem [RETIRED_SLOTS];
   logic        [ID_W-1:0]    rd_data_ff;
   logic                      rd_en;
   logic                      wr_en;

   logic                      take;
   logic                      out_free;
   logic                      bad_req;
   logic                      full;

   assign take     = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign bad_req  = (id_ff == '0) || (stamp_ff <= 0);
   assign full     = (count_ff >= CNT_W'(RETIRED_SLOTS));

   assign req_bus.ready        = (state_ff == ST_IDLE);
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.accept       = acc_ff;
   assign rsp_bus.transitioned = trans_ff;
   assign rsp_bus.replay       = replay_ff;
   assign rsp_bus.stale        = stale_ff;
   assign rsp_bus.invalid      = inv_ff;

   assign rd_en = (state_ff == ST_SCAN) && (idx_ff < count_ff);

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= retired_mem[idx_ff[IDX_W-1:0]];
      end
      if (wr_en) begin
         retired_mem[count_ff[IDX_W-1:0]] <= cur_id_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cur_id_in    = cur_id_ff;
      latest_in    = latest_ff;
      count_in     = count_ff;
      id_in        = id_ff;
      stamp_in     = stamp_ff;
      idx_in       = idx_ff;
      pend_in      = 1'b0;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      acc_in       = acc_ff;
      trans_in     = trans_ff;
      replay_in    = replay_ff;
      stale_in     = stale_ff;
      inv_in       = inv_ff;
      wr_en        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               id_in    = req_bus.producer_id;
               stamp_in = req_bus.source_stamp;
               idx_in   = '0;
               hit_in   = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // compare the entry read last cycle, issue the next read
            if (pend_ff && (rd_data_ff == id_ff)) begin
               hit_in = 1'b1;
            end
            if (rd_en) begin
               idx_in  = idx_ff + CNT_W'(1);
               pend_in = 1'b1;
            end else if (!pend_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               acc_in       = 1'b0;
               trans_in     = 1'b0;
               replay_in    = 1'b0;
               stale_in     = 1'b0;
               inv_in       = 1'b0;
               state_in     = ST_IDLE;
               if (bad_req) begin
                  inv_in = 1'b1;
               end else if (cur_id_ff == '0) begin
                  cur_id_in = id_ff;
                  latest_in = stamp_ff;
                  acc_in    = 1'b1;
                  trans_in  = 1'b1;
               end else if (id_ff == cur_id_ff) begin
                  if (stamp_ff < latest_ff) begin
                     stale_in = 1'b1;
                  end else if (stamp_ff == latest_ff) begin
                     acc_in    = 1'b1;
                     replay_in = 1'b1;
                  end else begin
                     latest_in = stamp_ff;
                     acc_in    = 1'b1;
                  end
               end else if (hit_ff || (stamp_ff <= latest_ff)) begin
                  stale_in = 1'b1;
               end else if (full) begin
                  inv_in = 1'b1;
               end else begin
                  // retire the current producer and hand over
                  wr_en     = 1'b1;
                  count_in  = count_ff + CNT_W'(1);
                  cur_id_in = id_ff;
                  latest_in = stamp_ff;
                  acc_in    = 1'b1;
                  trans_in  = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_id_ff    <= '0;
         latest_ff    <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_id_ff    <= cur_id_in;
         latest_ff    <= latest_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff     <= id_in;
      stamp_ff  <= stamp_in;
      idx_ff    <= idx_in;
      hit_ff    <= hit_in;
      acc_ff    <= acc_in;
      trans_ff  <= trans_in;
      replay_ff <= replay_in;
      stale_ff  <= stale_in;
      inv_ff    <= inv_in;
   end

endmodule
